>>> rtl/core/gbn_pkg.sv
// gbn_pkg: shared constants, codes and the result record of the go-back-n sender window
// used by the top level and the bench; its STORE_DEPTH sets the depth of the generic ram
package gbn_pkg;

  // window geometry
  localparam int WINDOW_SLOTS = 4;
  localparam int SLOT_W       = 2;
  localparam int SEQ_W        = 4;
  localparam int MAX_PAYLOAD  = 128;
  localparam int IDX_W        = 7;
  localparam int LEN_W        = 8;
  localparam int CNT_W        = 3;
  localparam int STORE_DEPTH  = WINDOW_SLOTS * MAX_PAYLOAD;

  // stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd1;
  localparam logic [7:0]  DATA_TYPE_RESET = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

  // input commands
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_STALE_ACK = 2'd2;
  localparam logic [1:0] STAT_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] seq_number;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0] length;
    logic [7:0]       checksum;
    logic [7:0]       read_data;
    logic [1:0]       status;
    logic [CNT_W-1:0] outstanding;
    logic [SEQ_W-1:0] base_seq;
    logic             last;
  } result_t;

endpackage

>>> rtl/core/go_back_n_sender_window_top.sv
// go_back_n_sender_window_top: go-back-n sender window, four slots, sequence numbers mod 16
// depends on gbn_pkg and gbn_ram (payload store)
//
//  port group   dir  beat contents
//  s_*          in   tuser cmd; tlast last_byte; tdata see port list
//  m_*          out  tuser kind; tlast last result of an item; tdata see port list
//  cfg_*        in   write of data_type_code (index 0) or timeout_ticks (index 1)
//
// a payload byte, ack or tick without timeout is taken in ST_IDLE; its result
// beat is registered on the accepting edge. a read then waits in ST_READ for the
// registered read data of the payload ram. a timeout moves to ST_RESEND, which sends
// one descriptor per outstanding packet, one beat a cycle while the output is free.
// reset: control state and registers clear at once; the payload store and the
// slot tables are not cleared. slot table entries are only read once written.
// stalls: an item is taken only when the output register is empty or draining
// in the same cycle; a held result beat stalls the resend and read sequences.

module go_back_n_sender_window_top
  import gbn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // data_byte[7:0], ack_seq[11:8], read_slot[13:12], read_index[20:14], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,   // last_byte
  input  logic [1:0]            s_tuser,   // cmd
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // seq_number[3:0], slot[5:4], length[13:6], checksum[21:14], read_data[29:22],
  // status[31:30], outstanding[34:32], base_seq[38:35], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,   // last
  output logic [1:0]            m_tuser,   // kind
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_RESEND = 2'd2;

  logic [1:0]        state, state_next;
  logic [SEQ_W-1:0]  window_base, window_base_next;
  logic [SLOT_W-1:0] base_slot, base_slot_next;
  logic [CNT_W-1:0]  pending_count, pending_count_next;
  logic [LEN_W-1:0]  fill_index, fill_index_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [SLOT_W-1:0] resend_idx, resend_idx_next;
  logic [7:0]        data_type_code;
  logic [15:0]       timeout_ticks;
  logic              out_valid, out_valid_next;
  result_t           out_q, out_q_next;

  // per-slot packet descriptors
  logic [LEN_W-1:0]  slot_length   [WINDOW_SLOTS];
  logic [7:0]        slot_checksum [WINDOW_SLOTS];
  logic              slot_we;
  logic [LEN_W-1:0]  slot_wr_len;
  logic [7:0]        slot_wr_ck;

  // input fields
  logic [7:0]        data_byte;
  logic [SEQ_W-1:0]  ack_seq;
  logic [SLOT_W-1:0] read_slot;
  logic [IDX_W-1:0]  read_index;

  logic              out_free;
  logic              in_fire;

  // payload fill path
  logic [SLOT_W-1:0] fill_slot;
  logic              window_full;
  logic              too_long;
  logic [LEN_W-1:0]  fill_len;
  logic [7:0]        fill_xor;
  logic [SEQ_W-1:0]  fill_seq;
  logic [7:0]        fill_ck;

  // timer
  logic [15:0]       tick_inc;
  logic [15:0]       tick_limit;

  // resend descriptor
  logic [SLOT_W-1:0] desc_slot;
  logic [SEQ_W-1:0]  desc_seq;
  logic              desc_last;

  // payload ram
  logic                              ram_we;
  logic [$clog2(STORE_DEPTH)-1:0]    ram_wr_addr;
  logic                              ram_re;
  logic [$clog2(STORE_DEPTH)-1:0]    ram_rd_addr;
  logic [7:0]                        ram_rd_data;

  result_t res;

  assign data_byte  = s_tdata[7:0];
  assign ack_seq    = s_tdata[11:8];
  assign read_slot  = s_tdata[13:12];
  assign read_index = s_tdata[20:14];

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;

  // next free slot and the message being gathered there
  assign fill_slot   = base_slot + pending_count[SLOT_W-1:0];
  assign window_full = pending_count >= CNT_W'(WINDOW_SLOTS);
  assign too_long    = fill_index >= LEN_W'(MAX_PAYLOAD);
  assign fill_len    = too_long ? fill_index : fill_index + LEN_W'(1);
  assign fill_xor    = too_long ? running_xor : running_xor ^ data_byte;
  assign fill_seq    = window_base + SEQ_W'(pending_count);
  assign fill_ck     = data_type_code ^ fill_len ^ {{(8-SEQ_W){1'b0}}, fill_seq} ^ fill_xor;

  // saturating tick counter, zero timeout acts as one
  assign tick_inc   = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign tick_limit = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;

  assign desc_slot = base_slot + resend_idx;
  assign desc_seq  = window_base + SEQ_W'(resend_idx);
  assign desc_last = ({1'b0, resend_idx} + CNT_W'(1)) == pending_count;

  assign ram_we      = in_fire && (s_tuser == CMD_DATA) && !window_full && !too_long;
  assign ram_wr_addr = {fill_slot, fill_index[IDX_W-1:0]};
  assign ram_re      = in_fire && (s_tuser == CMD_READ);
  assign ram_rd_addr = {read_slot, read_index};

  gbn_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_payload (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (data_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next         = state;
    window_base_next   = window_base;
    base_slot_next     = base_slot;
    pending_count_next = pending_count;
    fill_index_next    = fill_index;
    running_xor_next   = running_xor;
    tick_count_next    = tick_count;
    resend_idx_next    = resend_idx;
    out_valid_next     = out_valid && !m_tready;
    out_q_next         = out_q;
    slot_we            = 1'b0;
    slot_wr_len        = fill_len;
    slot_wr_ck         = fill_ck;
    res                = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          res.kind = KIND_STATUS;
          res.last = 1'b1;
          unique case (s_tuser)
            CMD_DATA: begin
              if (window_full) begin
                res.status = STAT_FULL;
              end else begin
                res.status = too_long ? STAT_TOO_LONG : STAT_OK;
                if (!too_long) begin
                  fill_index_next  = fill_len;
                  running_xor_next = fill_xor;
                end
                if (s_tlast) begin
                  // close the message and describe it
                  slot_we = 1'b1;
                  if (pending_count == '0) begin
                    tick_count_next = '0;
                  end
                  pending_count_next = pending_count + CNT_W'(1);
                  fill_index_next    = '0;
                  running_xor_next   = '0;
                  res.kind       = KIND_SEND;
                  res.seq_number = fill_seq;
                  res.slot       = fill_slot;
                  res.length     = fill_len;
                  res.checksum   = fill_ck;
                end
              end
            end
            CMD_ACK: begin
              if ((pending_count != '0) && (ack_seq == window_base)) begin
                window_base_next   = window_base + SEQ_W'(1);
                base_slot_next     = base_slot + SLOT_W'(1);
                pending_count_next = pending_count - CNT_W'(1);
                tick_count_next    = '0;
              end else begin
                res.status = STAT_STALE_ACK;
              end
            end
            CMD_TICK: begin
              if (pending_count == '0) begin
                tick_count_next = '0;
              end else if (tick_inc >= tick_limit) begin
                // timeout: resend the whole window, oldest first
                tick_count_next = '0;
                resend_idx_next = '0;
                state_next      = ST_RESEND;
              end else begin
                tick_count_next = tick_inc;
              end
            end
            CMD_READ: begin
              state_next = ST_READ;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
          res.outstanding = pending_count_next;
          res.base_seq    = window_base_next;
          if (state_next == ST_IDLE) begin
            out_valid_next = 1'b1;
            out_q_next     = res;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          res.kind        = KIND_READ;
          res.read_data   = ram_rd_data;
          res.status      = STAT_OK;
          res.outstanding = pending_count;
          res.base_seq    = window_base;
          res.last        = 1'b1;
          out_valid_next  = 1'b1;
          out_q_next      = res;
          state_next      = ST_IDLE;
        end
      end
      ST_RESEND: begin
        if (out_free) begin
          res.kind        = KIND_SEND;
          res.seq_number  = desc_seq;
          res.slot        = desc_slot;
          res.length      = slot_length[desc_slot];
          res.checksum    = slot_checksum[desc_slot];
          res.status      = STAT_OK;
          res.outstanding = pending_count;
          res.base_seq    = window_base;
          res.last        = desc_last;
          out_valid_next  = 1'b1;
          out_q_next      = res;
          if (desc_last) begin
            state_next = ST_IDLE;
          end else begin
            resend_idx_next = resend_idx + SLOT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_base   <= '0;
      base_slot     <= '0;
      pending_count <= '0;
      fill_index    <= '0;
      running_xor   <= '0;
      tick_count    <= '0;
      resend_idx    <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      window_base   <= window_base_next;
      base_slot     <= base_slot_next;
      pending_count <= pending_count_next;
      fill_index    <= fill_index_next;
      running_xor   <= running_xor_next;
      tick_count    <= tick_count_next;
      resend_idx    <= resend_idx_next;
      out_valid     <= out_valid_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_type_code <= DATA_TYPE_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATA_TYPE: data_type_code <= cfg_data[7:0];
        REG_TIMEOUT:   timeout_ticks  <= cfg_data;
        default:       timeout_ticks  <= timeout_ticks;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_q <= out_q_next;
    if (slot_we) begin
      slot_length[fill_slot]   <= slot_wr_len;
      slot_checksum[fill_slot] <= slot_wr_ck;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.kind;
  assign m_tlast  = out_q.last;
  assign m_tdata  = {1'b0, out_q.base_seq, out_q.outstanding, out_q.status,
                     out_q.read_data, out_q.checksum, out_q.length, out_q.slot,
                     out_q.seq_number};

endmodule

>>> rtl/core/gbn_ram.sv
// gbn_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> tb/go_back_n_sender_window_top_tb.sv
// go_back_n_sender_window_top_tb: self-checking bench for the go-back-n sender window
// depends on gbn_pkg and go_back_n_sender_window_top; keeps its own window model
// and checks every result beat against it, under random stalls on both stream sides
module go_back_n_sender_window_top_tb;
  import gbn_pkg::*;

  localparam int SEQ_MOD     = 1 << SEQ_W;
  localparam int HOLD_CYCLES = 120;
  localparam int RUN_LIMIT   = 600000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic [1:0]            s_tuser = CMD_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic [1:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DATA_TYPE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  go_back_n_sender_window_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // window model: state mirrors the sender after every accepted beat
  logic [7:0] store_mirror [0:STORE_DEPTH-1];
  logic [7:0] slot_len [0:WINDOW_SLOTS-1];
  logic [7:0] slot_ck [0:WINDOW_SLOTS-1];
  int         fill_mark [0:WINDOW_SLOTS-1];   // bytes 0..mark-1 of a slot have been written
  int         win_base, base_slot, pending, fill_idx, tick_cnt;
  logic [7:0] run_xor;
  logic [7:0] type_code = DATA_TYPE_RESET;
  int         timeout_lim = TIMEOUT_RESET;

  result_t beats_due [$];

  // stimulus shaping and bookkeeping
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int descriptors = 0;
  int resends = 0;
  int input_stalls = 0;
  int reg_writes = 0;
  int mismatches = 0;

  initial begin
    win_base = 0; base_slot = 0; pending = 0; fill_idx = 0; tick_cnt = 0; run_xor = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) fill_mark[i] = 0;
  end

  function automatic result_t status_beat(logic [1:0] kind, logic [7:0] rd, logic [1:0] st);
    result_t r;
    r = '0;
    r.kind = kind;
    r.read_data = rd;
    r.status = st;
    return r;
  endfunction

  // descriptor for the packet `offset` places past the window base
  function automatic result_t describe_slot(int offset, logic [1:0] st);
    result_t r;
    int s;
    s = (base_slot + offset) % WINDOW_SLOTS;
    r = '0;
    r.kind = KIND_SEND;
    r.seq_number = SEQ_W'((win_base + offset) % SEQ_MOD);
    r.slot = SLOT_W'(s);
    r.length = slot_len[s];
    r.checksum = slot_ck[s];
    r.status = st;
    descriptors++;
    return r;
  endfunction

  // advance the model by one accepted item and queue the beats it must cause
  function automatic void window_step(logic [1:0] cmd, logic [7:0] b, logic lst,
                                      logic [3:0] ack, logic [1:0] rs, logic [6:0] ri);
    result_t out [$];
    int s;
    int lim;
    logic [1:0] st;
    case (cmd)
      CMD_DATA: begin
        if (pending >= WINDOW_SLOTS) begin
          out.push_back(status_beat(KIND_STATUS, 8'd0, STAT_FULL));
        end else begin
          s = (base_slot + pending) % WINDOW_SLOTS;
          st = STAT_OK;
          if (fill_idx >= MAX_PAYLOAD) begin
            st = STAT_TOO_LONG;
          end else begin
            store_mirror[s * MAX_PAYLOAD + fill_idx] = b;
            run_xor ^= b;
            fill_idx++;
            if (fill_idx > fill_mark[s]) fill_mark[s] = fill_idx;
          end
          if (lst) begin
            slot_len[s] = 8'(fill_idx);
            slot_ck[s] = type_code ^ 8'(fill_idx) ^ 8'((win_base + pending) % SEQ_MOD) ^ run_xor;
            if (pending == 0) tick_cnt = 0;
            out.push_back(describe_slot(pending, st));
            pending++;
            fill_idx = 0;
            run_xor = '0;
          end else begin
            out.push_back(status_beat(KIND_STATUS, 8'd0, st));
          end
        end
      end
      CMD_ACK: begin
        if (pending > 0 && int'(ack) == win_base) begin
          win_base = (win_base + 1) % SEQ_MOD;
          base_slot = (base_slot + 1) % WINDOW_SLOTS;
          pending--;
          tick_cnt = 0;
          out.push_back(status_beat(KIND_STATUS, 8'd0, STAT_OK));
        end else begin
          out.push_back(status_beat(KIND_STATUS, 8'd0, STAT_STALE_ACK));
        end
      end
      CMD_TICK: begin
        // a zero timeout behaves as one tick
        lim = (timeout_lim == 0) ? 1 : timeout_lim;
        if (pending == 0) begin
          tick_cnt = 0;
        end else begin
          if (tick_cnt < 65535) tick_cnt++;
          if (tick_cnt >= lim) begin
            tick_cnt = 0;
            for (int i = 0; i < pending; i++) begin
              out.push_back(describe_slot(i, STAT_OK));
              resends++;
            end
          end
        end
        if (out.size() == 0) out.push_back(status_beat(KIND_STATUS, 8'd0, STAT_OK));
      end
      default: begin
        out.push_back(status_beat(KIND_READ, store_mirror[int'(rs) * MAX_PAYLOAD + int'(ri)],
                                  STAT_OK));
      end
    endcase
    foreach (out[k]) begin
      out[k].outstanding = CNT_W'(pending);
      out[k].base_seq = SEQ_W'(win_base);
      out[k].last = (k == out.size() - 1);
      beats_due.push_back(out[k]);
    end
  endfunction

  task automatic report_mismatch(input string field, input int got_v, input int want_v);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch in %s on result beat %0d: got %0d, expected %0d",
               field, beats_seen, got_v, want_v);
  endtask

  // output side: ready pattern, with a long hold-off whenever one is requested
  initial begin : sink_ready
    int seen = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin : check_beats
    result_t got;
    result_t want;
    if (!rst && s_tvalid && !s_tready) input_stalls++;
    if (!rst && m_tvalid && m_tready) begin
      got.kind        = m_tuser;
      got.seq_number  = m_tdata[3:0];
      got.slot        = m_tdata[5:4];
      got.length      = m_tdata[13:6];
      got.checksum    = m_tdata[21:14];
      got.read_data   = m_tdata[29:22];
      got.status      = m_tdata[31:30];
      got.outstanding = m_tdata[34:32];
      got.base_seq    = m_tdata[38:35];
      got.last        = m_tlast;
      if (beats_due.size() == 0) begin
        report_mismatch("unexpected beat kind", int'(got.kind), -1);
      end else begin
        want = beats_due.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.seq_number !== want.seq_number)
          report_mismatch("seq_number", got.seq_number, want.seq_number);
        if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.length !== want.length) report_mismatch("length", got.length, want.length);
        if (got.checksum !== want.checksum)
          report_mismatch("checksum", got.checksum, want.checksum);
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.outstanding !== want.outstanding)
          report_mismatch("outstanding", got.outstanding, want.outstanding);
        if (got.base_seq !== want.base_seq)
          report_mismatch("base_seq", got.base_seq, want.base_seq);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
      beats_seen++;
    end
  end

  // one input beat; returns at the falling edge after it was taken
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic lst,
                           input logic [3:0] ack, input logic [1:0] rs, input logic [6:0] ri);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tlast  <= lst;
    s_tdata  <= {3'b000, ri, rs, ack, b};
    do @(posedge clk); while (!s_tready);
    window_step(cmd, b, lst, ack, rs, ri);
    items_sent++;
    @(negedge clk);
  endtask

  // unused fields of each command carry random values
  task automatic send_byte(input logic [7:0] b, input logic lst);
    send_item(CMD_DATA, b, lst, 4'($urandom_range(15)), 2'($urandom_range(3)),
              7'($urandom_range(127)));
  endtask

  task automatic send_ack(input logic [3:0] ack);
    send_item(CMD_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)), ack,
              2'($urandom_range(3)), 7'($urandom_range(127)));
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              4'($urandom_range(15)), 2'($urandom_range(3)), 7'($urandom_range(127)));
  endtask

  task automatic send_read(input logic [1:0] rs, input logic [6:0] ri);
    send_item(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
              4'($urandom_range(15)), rs, ri);
  endtask

  // read only bytes that have been written at some point
  task automatic send_random_read();
    int sl;
    if (fill_mark[0] + fill_mark[1] + fill_mark[2] + fill_mark[3] == 0) begin
      send_tick();
    end else begin
      do sl = $urandom_range(WINDOW_SLOTS - 1); while (fill_mark[sl] == 0);
      send_read(2'(sl), 7'($urandom_range(fill_mark[sl] - 1)));
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_ack(4'($urandom_range(15)));
      1: send_tick();
      default: send_random_read();
    endcase
  endtask

  task automatic send_message(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(9) == 0) send_noise();
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic ack_all();
    while (pending > 0) send_ack(4'(win_base));
  endtask

  // drop valid and wait until every expected beat has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DATA_TYPE) type_code = val[7:0];
    else timeout_lim = int'(val);
    reg_writes++;
  endtask

  // idle tick and stale acks, fill to a full window, rejected byte, reads, slide
  task automatic test_window_basics();
    send_tick();
    send_ack(4'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_ack(4'd5);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b1);     // window full, dropped
    send_read(2'd0, 7'd0);
    send_read(2'd0, 7'd1);
    send_read(2'd3, 7'd0);
    send_ack(4'd0);
    send_byte(8'h81, 1'b1);     // reuses the freed slot
    send_ack(4'd2);             // not the base
    ack_all();
  endtask

  // zero timeout fires every tick, large one never, resend of a full window
  task automatic test_timeout_resend();
    write_reg(REG_TIMEOUT, 16'd0);
    write_reg(REG_DATA_TYPE, 16'h00FF);
    send_byte(8'h11, 1'b1);
    send_tick();
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h44, 1'b1);
    send_tick();
    send_byte(8'h55, 1'b1);
    send_tick();                // four descriptors
    write_reg(REG_TIMEOUT, 16'hFFFF);
    repeat (3) send_tick();
    write_reg(REG_TIMEOUT, 16'd3);
    repeat (3) send_tick();
    ack_all();
  endtask

  // message past the payload limit, closed by a dropped last byte
  task automatic test_long_message();
    int sl;
    write_reg(REG_DATA_TYPE, 16'h0000);
    sl = (base_slot + pending) % WINDOW_SLOTS;
    send_message(MAX_PAYLOAD + 2, 1'b0);
    send_read(2'(sl), 7'(MAX_PAYLOAD - 1));
    send_read(2'(sl), 7'd0);
    send_read(2'(sl), 7'd85);
    ack_all();
  endtask

  // messages, some past the payload limit, and acks, mixed with stale acks, ticks and reads
  task automatic test_random_traffic(input int budget);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_message(($urandom_range(39) == 0) ? $urandom_range(120, 131)
                                               : $urandom_range(1, 5), 1'b1);
      end else if (pick < 65) begin
        send_ack((pending > 0 && $urandom_range(4) != 0) ? 4'(win_base)
                                                        : 4'($urandom_range(15)));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else begin
        send_noise();
      end
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_tick();
      else send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
    end
    ack_all();
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(26, 83);
    test_window_basics();
    test_timeout_resend();
    test_long_message();

    write_reg(REG_DATA_TYPE, 16'h00FF);
    write_reg(REG_TIMEOUT, 16'd2);
    test_random_traffic(85);

    set_idling(83, 26);
    write_reg(REG_DATA_TYPE, 16'h0000);
    write_reg(REG_TIMEOUT, 16'd1);
    test_random_traffic(85);

    set_idling(0, 0);
    write_reg(REG_DATA_TYPE, 16'($urandom_range(255)));
    write_reg(REG_TIMEOUT, 16'd5);
    test_backpressure();
    test_random_traffic(85);

    settle();
    repeat (8) @(negedge clk);
    $display("run covered %0d input beats and %0d result beats, %0d of them descriptors",
             items_sent, beats_seen, descriptors);
    $display("%0d timeout resends, %0d register writes, %0d cycles of input stall",
             resends, reg_writes, input_stalls);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(20 * RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> go_back_n_sender_window_top.f
rtl/core/gbn_pkg.sv
rtl/core/gbn_ram.sv
rtl/core/go_back_n_sender_window_top.sv
tb/go_back_n_sender_window_top_tb.sv
